@@ src/pdd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the packed date to day number converter.
// Holds field widths, reciprocal constants, the item struct and the calendar tables.
package pdd_pkg;

  localparam int unsigned DateW   = 32;
  localparam int unsigned YearW   = 14;
  localparam int unsigned Dig2W   = 7;
  localparam int unsigned DayNumW = 23;
  localparam int unsigned CountW  = 22;
  localparam int unsigned DoyW    = 9;

  // v / 10000 == (v * Div10kMul) >> Div10kShift for every 32-bit v
  localparam logic [31:0] Div10kMul   = 32'hD1B7_1759;
  localparam int unsigned Div10kShift = 45;
  // x / 100 == (x * Div100Mul) >> Div100Shift for x below 43699
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;

  localparam logic [YearW-1:0]   YearMax     = 14'd9999;
  localparam logic [3:0]         MonFeb      = 4'd2;
  localparam logic [3:0]         MonDec      = 4'd12;
  localparam logic [DayNumW-1:0] EpochOffset = 23'd719468;

  // Split fields of one date, handed from the decimal splitter to the day counter
  typedef struct packed {
    logic             year_ok;
    logic             mon_ok;
    logic [YearW-1:0] year;
    logic [Dig2W-1:0] year_hi;  // year / 100
    logic [Dig2W-1:0] year_lo;  // year % 100
    logic [3:0]       month;
    logic [Dig2W-1:0] day;
  } split_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of a month, counting from March
  function automatic logic [DoyW-1:0] doy_base(input logic [3:0] mp);
    logic [DoyW-1:0] base;
    case (mp)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

@@ src/packed_date_to_day_number.sv @@
`timescale 1ns / 1ps
// Packed YYYYMMDD date to signed day count since 1970-01-01.
// One request per cycle sustained while the output is not stalled,
// set by the seven-stage pipeline with per-stage valid bits and a ready chain.
// A stalled output holds its result while empty stages upstream keep filling.
// Synchronous active-low reset clears the valid bits only. Depends on pdd_pkg.
module packed_date_to_day_number
  import pdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] packed_date
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [22:0] day_number, [23] zero
  output logic [0:0]  out_tuser   // [0] date_ok
);

  logic               mid_valid;
  logic               mid_ready;
  split_t             mid_data;
  logic               res_ok;
  logic [DayNumW-1:0] res_days;

  pdd_split u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_date  (in_tdata),
    .m_valid (mid_valid),
    .m_ready (mid_ready),
    .m_data  (mid_data)
  );

  pdd_count u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (mid_valid),
    .s_ready (mid_ready),
    .s_data  (mid_data),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_ok    (res_ok),
    .m_days  (res_days)
  );

  assign out_tdata = {1'b0, res_days};
  assign out_tuser = res_ok;

endmodule

@@ src/pdd_split.sv @@
`timescale 1ns / 1ps
// Decimal splitter: YYYYMMDD into year, month and day over four stages.
// Depends on pdd_pkg.
module pdd_split
  import pdd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [DateW-1:0] s_date,
  output logic             m_valid,
  input  logic             m_ready,
  output split_t           m_data
);

  localparam int unsigned NStg = 4;

  logic [NStg-1:0] vld_r;
  logic [NStg-1:0] vld_nxt;
  logic [NStg:0]   rdy;

  // stage 1
  logic [18:0]      a_q_r, a_q_nxt;
  logic [DateW-1:0] a_v_r;
  logic [63:0]      a_prod;
  // stage 2
  logic [YearW-1:0] b_r_r, b_r_nxt;
  logic [YearW-1:0] b_y_r;
  logic             b_yok_r, b_yok_nxt;
  logic [32:0]      b_prod;
  logic [DateW-1:0] b_rem;
  // stage 3
  logic [Dig2W-1:0] c_m_r, c_m_nxt;
  logic [Dig2W-1:0] c_yh_r, c_yh_nxt;
  logic [YearW-1:0] c_r_r, c_y_r;
  logic             c_yok_r;
  logic [26:0]      c_mprod, c_yprod;
  // stage 4
  split_t           d_r, d_nxt;
  logic [YearW-1:0] d_day, d_ylo;

  always_comb begin
    rdy[NStg] = m_ready;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = {vld_r[NStg-2:0], s_valid};
  end

  assign s_ready = rdy[0];
  assign m_valid = vld_r[NStg-1];
  assign m_data  = d_r;

  always_comb begin
    a_prod  = 64'(s_date) * 64'(Div10kMul);
    a_q_nxt = a_prod[Div10kShift +: 19];

    b_prod    = 33'(a_q_r) * 33'd10000;
    b_rem     = a_v_r - b_prod[DateW-1:0];
    b_r_nxt   = b_rem[YearW-1:0];
    b_yok_nxt = (a_q_r != 19'd0) && (a_q_r <= 19'(YearMax));

    c_mprod  = 27'(b_r_r) * 27'(Div100Mul);
    c_yprod  = 27'(b_y_r) * 27'(Div100Mul);
    c_m_nxt  = c_mprod[Div100Shift +: Dig2W];
    c_yh_nxt = c_yprod[Div100Shift +: Dig2W];

    d_day = c_r_r - 14'(c_m_r) * 14'd100;
    d_ylo = c_y_r - 14'(c_yh_r) * 14'd100;
    d_nxt.year_ok = c_yok_r;
    d_nxt.mon_ok  = (c_m_r != 7'd0) && (c_m_r <= 7'(MonDec));
    d_nxt.year    = c_y_r;
    d_nxt.year_hi = c_yh_r;
    d_nxt.year_lo = d_ylo[Dig2W-1:0];
    d_nxt.month   = c_m_r[3:0];
    d_nxt.day     = d_day[Dig2W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_q_r <= a_q_nxt;
      a_v_r <= s_date;
    end
    if (rdy[1]) begin
      b_r_r   <= b_r_nxt;
      b_y_r   <= a_q_r[YearW-1:0];
      b_yok_r <= b_yok_nxt;
    end
    if (rdy[2]) begin
      c_m_r   <= c_m_nxt;
      c_yh_r  <= c_yh_nxt;
      c_r_r   <= b_r_r;
      c_y_r   <= b_y_r;
      c_yok_r <= b_yok_r;
    end
    if (rdy[3]) begin
      d_r <= d_nxt;
    end
  end

endmodule

@@ src/pdd_count.sv @@
`timescale 1ns / 1ps
// Day counter: date check and era day count relative to 1970-01-01, three stages.
// Depends on pdd_pkg.
module pdd_count
  import pdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s_valid,
  output logic               s_ready,
  input  split_t             s_data,
  output logic               m_valid,
  input  logic               m_ready,
  output logic               m_ok,
  output logic [DayNumW-1:0] m_days
);

  localparam int unsigned NStg = 3;

  logic [NStg-1:0] vld_r;
  logic [NStg-1:0] vld_nxt;
  logic [NStg:0]   rdy;

  // stage 5
  logic             leap;
  logic [4:0]       limit;
  logic [YearW-1:0] shifted;
  logic [3:0]       mp;
  logic [26:0]      sh_prod;
  logic             e_ok_r, e_ok_nxt;
  logic [YearW-1:0] e_s_r;
  logic [Dig2W-1:0] e_sh_r, e_sh_nxt;
  logic [DoyW-1:0]  e_doy_r, e_doy_nxt;
  // stage 6
  logic              f_ok_r;
  logic [CountW-1:0] f_part_r, f_part_nxt;
  logic [DoyW-1:0]   f_doy_r;
  // stage 7
  logic [DayNumW-1:0] g_sum;
  logic               g_ok_r;
  logic [DayNumW-1:0] g_days_r, g_days_nxt;

  always_comb begin
    rdy[NStg] = m_ready;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = {vld_r[NStg-2:0], s_valid};
  end

  assign s_ready = rdy[0];
  assign m_valid = vld_r[NStg-1];
  assign m_ok    = g_ok_r;
  assign m_days  = g_days_r;

  always_comb begin
    // 400/4/100 rule; y % 4 equals (y % 100) % 4
    leap  = (s_data.year_lo == 7'd0) ? (s_data.year_hi[1:0] == 2'd0)
                                     : (s_data.year_lo[1:0] == 2'd0);
    limit = month_len(s_data.month)
            + 5'((s_data.month == MonFeb) && leap);
    e_ok_nxt = s_data.year_ok && s_data.mon_ok && (s_data.day != 7'd0)
               && (s_data.day <= 7'(limit));

    // year starts in March
    shifted   = (s_data.month <= MonFeb) ? s_data.year - 14'd1 : s_data.year;
    mp        = (s_data.month > MonFeb) ? s_data.month - 4'd3 : s_data.month + 4'd9;
    sh_prod   = 27'(shifted) * 27'(Div100Mul);
    e_sh_nxt  = sh_prod[Div100Shift +: Dig2W];
    e_doy_nxt = doy_base(mp) + 9'(s_data.day) - 9'd1;

    // s*365 + s/4 - s/100 + s/400
    f_part_nxt = 22'(e_s_r) * 22'd365 + 22'(e_s_r >> 2)
                 + 22'(e_sh_r >> 2) - 22'(e_sh_r);

    g_sum      = {1'b0, f_part_r} + 23'(f_doy_r) - EpochOffset;
    g_days_nxt = f_ok_r ? g_sum : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      e_ok_r  <= e_ok_nxt;
      e_s_r   <= shifted;
      e_sh_r  <= e_sh_nxt;
      e_doy_r <= e_doy_nxt;
    end
    if (rdy[1]) begin
      f_ok_r   <= e_ok_r;
      f_part_r <= f_part_nxt;
      f_doy_r  <= e_doy_r;
    end
    if (rdy[2]) begin
      g_ok_r   <= f_ok_r;
      g_days_r <= g_days_nxt;
    end
  end

endmodule

@@ src/pdd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for packed_date_to_day_number, bound to the top level.
// Depends on the top level's port list only.
module pdd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a held result must not change while the consumer stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed under stall");

  // no stall anywhere when the consumer is ready
  a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("request refused while output ready");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 24'd0)
    else $error("invalid date with non-zero day count");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      !out_tdata[23] && ($signed(out_tdata[22:0]) >= -23'sd719162)
      && ($signed(out_tdata[22:0]) <= 23'sd2932896))
    else $error("day count out of calendar range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  logic unused_in;
  assign unused_in = in_tvalid ^ (^in_tdata);

endmodule

bind packed_date_to_day_number pdd_checker u_pdd_checker (.*);
